// ----- hdl/gbn_pkg.sv -----
// gbn_pkg: shared types and constants for the greedy box nms block
// holds controller states, command and status structs and register codes
// no dependencies
`default_nettype none

package gbn_pkg;

    // default sizes for the top level parameters
    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_BITS_DEF = 14;

    // fixed field widths
    localparam int IDX_W      = 16;
    localparam int THR_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register map, indexed by paddr[2]
    localparam logic [0:0] REG_IOU_THRESHOLD = 1'b0;

    // threshold after reset, 0.4 in q0.16
    localparam logic [THR_W-1:0] IOU_THRESHOLD_RESET = 16'd26214;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } gbn_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture request, start a new box
        logic issue;   // read one kept box and push it down the compare pipe
        logic finish;  // settle keep decision, update store, post result
    } gbn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;   // every kept box has been issued
        logic pipe_empty;  // no compare in flight
        logic out_free;    // result register can take a new result
    } gbn_status_t;

endpackage : gbn_pkg

`default_nettype wire

// ----- hdl/gbn_regs.sv -----
// gbn_regs: apb configuration register for the iou threshold
// depends on gbn_pkg
`default_nettype none

module gbn_regs
    import gbn_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [THR_W-1:0]      iou_threshold
);

    logic [THR_W-1:0] thr_reg;
    logic             sel_thr;
    logic             wr_en;

    // register decode, word index sits above the byte offset
    assign sel_thr = (paddr[APB_ADDR_W-1:2] == REG_IOU_THRESHOLD);
    assign wr_en   = psel && penable && pwrite && sel_thr;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= IOU_THRESHOLD_RESET;
        end
        else if (wr_en)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (sel_thr)
        begin
            prdata = APB_DATA_W'(thr_reg);
        end
    end

    assign pready        = 1'b1;
    assign iou_threshold = thr_reg;

endmodule : gbn_regs

`default_nettype wire

// ----- hdl/gbn_ctrl.sv -----
// gbn_ctrl: controller state machine sequencing one box through the scan
// depends on gbn_pkg
`default_nettype none

module gbn_ctrl
    import gbn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire gbn_status_t status,
    output gbn_cmd_t         cmd
);

    gbn_state_t state_reg;
    gbn_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : gbn_ctrl

`default_nettype wire

// ----- hdl/gbn_datapath.sv -----
// gbn_datapath: box registers, kept box memory, iou compare pipeline and result register
// depends on gbn_pkg
`default_nettype none

module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gbn_cmd_t                     cmd,
    output gbn_status_t                       status,
    input  wire logic      [THR_W-1:0]        iou_threshold,
    input  wire logic                         first_of_frame,
    input  wire logic signed [COORD_BITS-1:0] box_left,
    input  wire logic signed [COORD_BITS-1:0] box_top,
    input  wire logic      [COORD_BITS-2:0]   box_width,
    input  wire logic      [COORD_BITS-2:0]   box_height,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              keep,
    output logic           [IDX_W-1:0]        box_index,
    output logic                              kept_overflow
);

    localparam int SIZE_W  = COORD_BITS - 1;
    localparam int EDGE_W  = COORD_BITS + 1;
    localparam int AREA_W  = 2 * SIZE_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int PROD_W  = THR_W + UNI_W;
    localparam int CNT_W   = $clog2(MAX_KEPT + 1);
    localparam int ADDR_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int ENTRY_W = 2 * COORD_BITS + 2 * SIZE_W + AREA_W;

    // overlap of two intervals, zero when they miss
    function automatic logic [SIZE_W-1:0] overlap_len(
        input logic signed [EDGE_W-1:0] a0,
        input logic        [SIZE_W-1:0] alen,
        input logic signed [EDGE_W-1:0] b0,
        input logic        [SIZE_W-1:0] blen
    );
        logic signed [EDGE_W-1:0] lo;
        logic signed [EDGE_W-1:0] ea;
        logic signed [EDGE_W-1:0] eb;
        logic signed [EDGE_W-1:0] hi;
        logic signed [EDGE_W-1:0] diff;
        lo   = (a0 > b0) ? a0 : b0;
        ea   = a0 + $signed({2'b00, alen});
        eb   = b0 + $signed({2'b00, blen});
        hi   = (ea < eb) ? ea : eb;
        diff = hi - lo;
        overlap_len = (hi > lo) ? diff[SIZE_W-1:0] : '0;
    endfunction

    // current box
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic        [SIZE_W-1:0]     w_reg;
    logic        [SIZE_W-1:0]     h_reg;
    logic        [AREA_W-1:0]     area_reg;
    logic        [AREA_W-1:0]     area_next;
    logic        [IDX_W-1:0]      cur_index_reg;
    logic        [IDX_W-1:0]      cur_index_next;

    // frame state
    logic [CNT_W-1:0] kept_count_reg;
    logic [IDX_W-1:0] frame_index_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             suppress_reg;
    logic             store_full;
    logic             wr_en;

    // kept box memory
    logic [ENTRY_W-1:0] kept_mem [MAX_KEPT];
    logic [ENTRY_W-1:0] mem_q_reg;

    // compare pipeline
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [COORD_BITS-1:0] k_left;
    logic signed [COORD_BITS-1:0] k_top;
    logic        [SIZE_W-1:0]     k_width;
    logic        [SIZE_W-1:0]     k_height;
    logic        [AREA_W-1:0]     k_area;
    logic        [SIZE_W-1:0]     ix_reg;
    logic        [SIZE_W-1:0]     iy_reg;
    logic        [AREA_W-1:0]     karea2_reg;
    logic        [AREA_W-1:0]     inter3_reg;
    logic        [AREA_W-1:0]     karea3_reg;
    logic        [UNI_W-1:0]      uni4_reg;
    logic        [AREA_W-1:0]     inter4_reg;
    logic        [PROD_W-1:0]     prod5_reg;
    logic        [AREA_W-1:0]     inter5_reg;
    logic        [PROD_W-1:0]     lhs5;

    // result register
    logic             out_valid_reg;
    logic             keep_reg;
    logic             ovf_reg;
    logic [IDX_W-1:0] index_reg;

    assign area_next      = AREA_W'(box_width) * AREA_W'(box_height);
    assign cur_index_next = first_of_frame ? '0 : frame_index_reg;
    assign store_full     = (kept_count_reg >= CNT_W'(MAX_KEPT));
    assign wr_en          = cmd.finish && !suppress_reg && !store_full;

    // box capture on request accept
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg         <= box_left;
            y_reg         <= box_top;
            w_reg         <= box_width;
            h_reg         <= box_height;
            area_reg      <= area_next;
            cur_index_reg <= cur_index_next;
        end
    end

    // frame counters, scan address and suppress flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count_reg  <= '0;
            frame_index_reg <= '0;
            scan_idx_reg    <= '0;
            suppress_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                frame_index_reg <= cur_index_next + IDX_W'(1);
                scan_idx_reg    <= '0;
                suppress_reg    <= 1'b0;
                if (first_of_frame)
                begin
                    kept_count_reg <= '0;
                end
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (v5_reg && (lhs5 > prod5_reg))
                begin
                    suppress_reg <= 1'b1;
                end
                if (wr_en)
                begin
                    kept_count_reg <= kept_count_reg + CNT_W'(1);
                end
            end
        end
    end

    // memory write, appends a surviving box
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kept_mem[kept_count_reg[ADDR_W-1:0]] <= {x_reg, y_reg, w_reg, h_reg, area_reg};
        end
    end

    // memory read, one kept box per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            mem_q_reg <= kept_mem[scan_idx_reg[ADDR_W-1:0]];
        end
    end

    assign {k_left, k_top, k_width, k_height, k_area} = mem_q_reg;

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // overlaps, intersection, union, threshold product
    always_ff @(posedge clk)
    begin
        ix_reg     <= overlap_len({x_reg[COORD_BITS-1], x_reg}, w_reg,
                                  {k_left[COORD_BITS-1], k_left}, k_width);
        iy_reg     <= overlap_len({y_reg[COORD_BITS-1], y_reg}, h_reg,
                                  {k_top[COORD_BITS-1], k_top}, k_height);
        karea2_reg <= k_area;

        inter3_reg <= AREA_W'(ix_reg) * AREA_W'(iy_reg);
        karea3_reg <= karea2_reg;

        uni4_reg   <= UNI_W'(area_reg) + UNI_W'(karea3_reg) - UNI_W'(inter3_reg);
        inter4_reg <= inter3_reg;

        prod5_reg  <= PROD_W'(iou_threshold) * PROD_W'(uni4_reg);
        inter5_reg <= inter4_reg;
    end

    // intersection scaled by 2^16
    assign lhs5 = PROD_W'({inter5_reg, {THR_W{1'b0}}});

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            keep_reg  <= !suppress_reg;
            ovf_reg   <= !suppress_reg && store_full;
            index_reg <= cur_index_reg;
        end
    end

    // status back to the controller
    always_comb
    begin
        status.scan_done  = (scan_idx_reg == kept_count_reg);
        status.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg);
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign keep          = keep_reg;
    assign box_index     = index_reg;
    assign kept_overflow = ovf_reg;

endmodule : gbn_datapath

`default_nettype wire

// ----- hdl/greedy_box_nms_top.sv -----
// greedy_box_nms_top: top level of the greedy box nms block
// depends on gbn_pkg, gbn_regs, gbn_ctrl, gbn_datapath
`default_nettype none

// Greedy non-maximum suppression on integer boxes, taken one request at a
// time in falling score order. Each box is compared by exact IoU against
// every box kept so far in the frame, one kept box per cycle through the
// single read port of the kept box memory and a five stage compare pipe.
// The next box can be accepted in the cycle in which the last result shows.
// A result that waits on out_ready holds the next box at its final step
// until the output register frees. The next box is accepted while a result
// still waits in the output register. first_of_frame empties the kept list
// and restarts the box index. A surviving box that finds the store full is
// reported with kept_overflow set and is not stored. The IoU threshold
// (Q0.16, reset 0.4) sits at APB address 0 and should be written only while
// the block is idle.

module greedy_box_nms_top
    import gbn_pkg::*;
#(
    parameter int MAX_KEPT   = MAX_KEPT_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic      [APB_ADDR_W-1:0]   paddr,
    input  wire logic      [APB_DATA_W-1:0]   pwdata,
    output logic           [APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // box requests
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         first_of_frame,
    input  wire logic signed [COORD_BITS-1:0] box_left,
    input  wire logic signed [COORD_BITS-1:0] box_top,
    input  wire logic      [COORD_BITS-2:0]   box_width,
    input  wire logic      [COORD_BITS-2:0]   box_height,
    // results
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              keep,
    output logic           [IDX_W-1:0]        box_index,
    output logic                              kept_overflow
);

    logic [THR_W-1:0] iou_threshold;
    gbn_cmd_t         cmd;
    gbn_status_t      status;

    // configuration register
    gbn_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .iou_threshold (iou_threshold)
    );

    // sequencing
    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and compare
    gbn_datapath #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .iou_threshold  (iou_threshold),
        .first_of_frame (first_of_frame),
        .box_left       (box_left),
        .box_top        (box_top),
        .box_width      (box_width),
        .box_height     (box_height),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .keep           (keep),
        .box_index      (box_index),
        .kept_overflow  (kept_overflow)
    );

endmodule : greedy_box_nms_top

`default_nettype wire
